// ===== design/madc_pkg.sv =====
package madc_pkg;

	// sample and result width, signed Q1.15
	localparam int SMP_W = 16;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam int WIN_W  = 14;
	localparam int CHN_W  = 4;
	localparam int WET_W  = 16;

	localparam int MAX_WINDOW   = 8192;
	localparam int MAX_CHANNELS = 8;

	localparam int POS_W = $clog2(MAX_WINDOW);
	localparam int CH_W  = $clog2(MAX_CHANNELS);

	// history store: one ring of MAX_WINDOW entries per channel
	localparam int ADDR_W    = CH_W + POS_W;
	localparam int MEM_DEPTH = MAX_WINDOW * MAX_CHANNELS;

	// running sum: up to MAX_WINDOW full-scale samples
	localparam int SUM_W = SMP_W + POS_W;

	// divider: magnitude of the sum over the window length
	localparam int DVD_W     = SUM_W;
	localparam int DVS_W     = WIN_W;
	localparam int REM_W     = DVS_W + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// mean, product and accumulator
	localparam int MEAN_W = DVD_W + 1;
	localparam int PROD_W = MEAN_W + WET_W + 1;
	localparam int ACC_W  = PROD_W + 1;

	localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(4800);
	localparam logic [CHN_W-1:0] CHN_RST = CHN_W'(1);
	localparam logic [WET_W-1:0] WET_ONE = WET_W'(32768);

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_CHANS  = 2'd1,
		REG_WET    = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/madc_ram.sv =====
module madc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/madc_div.sv =====
module madc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  madc_pkg::div_req_t  req,
	output madc_pkg::div_rsp_t  rsp
);

	import madc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [REM_W-1:0] rem_sh;
	logic             ge;
	logic [REM_W-1:0] rem_d;

	// restoring division, one quotient bit a cycle; quotient shifts in behind the dividend
	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_d  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== design/moving_average_dc_removal.sv =====
// Channel   Direction  Transaction moves
// s_axis    in         one interleaved sample, tdata = sample (Q1.15)
// m_axis    out        one result, tdata = filtered (Q1.15)
// cfg       in         register write: 0 window_length, 1 channel_count, 2 wet_mix
//
// One sample at a time: the result is raised after its transaction has passed
// the history read, sum update and write-back, the divider, multiply and blend,
// and only then does the block return to idle to take the next sample.
// After reset a clearing pass zeroes all 65536 history entries, one a cycle;
// no sample is taken during the clearing pass. A stalled m_axis only holds
// the block once a further result is ready to leave the blend step.
module moving_average_dc_removal (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [madc_pkg::SMP_W-1:0]     s_axis_tdata,  // [15:0] sample
	// master side
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [madc_pkg::SMP_W-1:0]     m_axis_tdata,  // [15:0] filtered
	// configuration write port
	input  logic                           cfg_we,
	input  logic [madc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [madc_pkg::CFG_W-1:0]     cfg_data
);

	import madc_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [WIN_W-1:0] window_length_q;
	logic [CHN_W-1:0] channel_count_q;
	logic [WET_W-1:0] wet_mix_q;

	// frame position
	logic [CH_W-1:0]  cur_ch_q;
	logic [POS_W-1:0] ring_pos_q;

	// per-channel running sums, small enough for flops
	logic signed [SUM_W-1:0] sums_q [MAX_CHANNELS];

	logic [ADDR_W-1:0] clr_cnt_q;

	// per-sample working registers
	logic signed [SMP_W-1:0]  sample_s1;
	logic [CH_W-1:0]          ch_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic                     neg_s1;
	logic signed [MEAN_W-1:0] mean_s2;
	logic signed [PROD_W-1:0] prod_q;

	logic                    out_valid_q;
	logic [SMP_W-1:0]        out_data_q;

	// effective (clamped) configuration
	logic [WIN_W-1:0]   win_eff;
	logic [CHN_W-1:0]   chn_eff;
	logic [WET_W-1:0]   wet_eff;

	always_comb begin
		win_eff = window_length_q;
		if (window_length_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_length_q > WIN_W'(MAX_WINDOW)) begin
			win_eff = WIN_W'(MAX_WINDOW);
		end
		chn_eff = channel_count_q;
		if (channel_count_q == '0) begin
			chn_eff = CHN_W'(1);
		end else if (channel_count_q > CHN_W'(MAX_CHANNELS)) begin
			chn_eff = CHN_W'(MAX_CHANNELS);
		end
		wet_eff = (wet_mix_q > WET_ONE) ? WET_ONE : wet_mix_q;
	end

	// stale counters after reconfiguration restart at zero
	logic [CH_W-1:0]  ch_use;
	logic [POS_W-1:0] pos_use;
	logic [CH_W-1:0]  ch_next;
	logic [POS_W-1:0] pos_next;
	logic             frame_end;
	logic [POS_W:0]   pos_inc;

	always_comb begin
		ch_use    = ({1'b0, cur_ch_q} >= chn_eff) ? '0 : cur_ch_q;
		pos_use   = ({1'b0, ring_pos_q} >= win_eff) ? '0 : ring_pos_q;
		frame_end = ({1'b0, ch_use} + 1'b1) >= chn_eff;
		pos_inc   = {1'b0, pos_use} + 1'b1;
		ch_next   = frame_end ? '0 : ch_use + 1'b1;
		pos_next  = pos_use;
		if (frame_end) begin
			pos_next = (WIN_W'(pos_inc) >= win_eff) ? '0 : pos_inc[POS_W-1:0];
		end
	end

	logic in_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// history store
	logic              ram_we;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [SMP_W-1:0]  ram_wr_data;
	logic [SMP_W-1:0]  ram_rd_data;

	madc_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MEM_DEPTH)
	) u_hist (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.re     (in_acc),
		.rd_addr({ch_use, pos_use}),
		.rd_data(ram_rd_data)
	);

	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = addr_s1;
		ram_wr_data = sample_s1;
		if (state_q == ST_CLEAR) begin
			ram_we      = 1'b1;
			ram_wr_addr = clr_cnt_q;
			ram_wr_data = '0;
		end else if (state_q == ST_READ) begin
			ram_we = 1'b1;
		end
	end

	// sum update: add the new sample, drop the one it overwrites
	logic signed [SUM_W-1:0] sum_new;
	logic [DVD_W-1:0]        sum_mag;

	always_comb begin
		sum_new = sums_q[ch_s1] + SUM_W'(sample_s1) - SUM_W'($signed(ram_rd_data));
		sum_mag = sum_new[SUM_W-1] ? DVD_W'(-sum_new) : DVD_W'(sum_new);
	end

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start    = (state_q == ST_READ);
	assign div_req.dividend = sum_mag;
	assign div_req.divisor  = win_eff;

	madc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// truncation toward zero: divide the magnitude, then restore the sign
	logic signed [MEAN_W-1:0] quo_s;
	assign quo_s = $signed({1'b0, div_rsp.quotient});

	// blend: x*(1-wet) + (x-mean)*wet == x*2^15 - mean*wet
	logic signed [ACC_W-1:0]       acc;
	logic signed [ACC_W-15-1:0]    acc_sh;
	logic [SMP_W-1:0]              res;

	always_comb begin
		acc    = (ACC_W'(sample_s1) <<< 15) - ACC_W'(prod_q);
		acc_sh = acc[ACC_W-1:15];
		if (acc_sh > (ACC_W-15)'(SMP_MAX)) begin
			res = SMP_MAX;
		end else if (acc_sh < (ACC_W-15)'(SMP_MIN)) begin
			res = SMP_MIN;
		end else begin
			res = acc_sh[SMP_W-1:0];
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_cnt_q       <= '0;
			window_length_q <= WIN_RST;
			channel_count_q <= CHN_RST;
			wet_mix_q       <= WET_ONE;
			cur_ch_q        <= '0;
			ring_pos_q      <= '0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WINDOW: window_length_q <= cfg_data[WIN_W-1:0];
					REG_CHANS:  channel_count_q <= cfg_data[CHN_W-1:0];
					REG_WET:    wet_mix_q       <= cfg_data[WET_W-1:0];
					REG_NONE: ;
				endcase
			end

			// a new result replaces the one leaving in the same cycle
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {ADDR_W{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						cur_ch_q   <= ch_next;
						ring_pos_q <= pos_next;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					sums_q[ch_s1] <= sum_new;
					state_q       <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= $signed(s_axis_tdata);
			ch_s1     <= ch_use;
			addr_s1   <= {ch_use, pos_use};
		end
		if (state_q == ST_READ) begin
			neg_s1 <= sum_new[SUM_W-1];
		end
		if (div_rsp.done) begin
			mean_s2 <= neg_s1 ? -quo_s : quo_s;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mean_s2 * $signed({1'b0, wet_eff});
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// history is written only by the clearing pass or the read-modify-write step
	a_ram_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_READ))
		else $error("history write outside clear or update");

	// divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result with no sample in flight");

	// a new result appears only from the blend step
	a_out_from_blend: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || m_axis_tready) && state_q != ST_OUT |=> !out_valid_q)
		else $error("result raised without blend step");

	// no sample taken during the clearing pass
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=>
			(cur_ch_q == $past(cur_ch_q) && ring_pos_q == $past(ring_pos_q)))
		else $error("frame position moved during clearing pass");

endmodule
